@@ rtl/rfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, constants and the Adler-32 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int CHECK_BYTES  = 4;

    localparam logic [16:0] ADLER_MOD = 17'd65521;

    localparam logic [30:0] MIN_LENGTH_RST = 31'd8;
    localparam logic [30:0] MAX_LENGTH_RST = 31'd67108864;
    localparam logic [31:0] TAG_WORD_RST   = 32'd0;

    typedef enum logic [1:0] {
        CFG_MIN_LENGTH = 2'd0,
        CFG_MAX_LENGTH = 2'd1,
        CFG_TAG_WORD   = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_LENGTH   = 2'd1,
        VERDICT_CHECKSUM = 2'd2,
        VERDICT_TAG      = 2'd3
    } t_verdict;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        t_verdict    verdict;
    } t_result;

    // One Adler-32 byte step: returns {sum_high, sum_low}.
    function automatic logic [31:0] adler_step(input logic [15:0] sum_low,
                                               input logic [15:0] sum_high,
                                               input logic [7:0]  data);
        logic [16:0] low_sum;
        logic [16:0] high_sum;
        low_sum = {1'b0, sum_low} + {9'd0, data};
        if (low_sum >= ADLER_MOD) begin
            low_sum = low_sum - ADLER_MOD;
        end
        high_sum = {1'b0, sum_high} + low_sum;
        if (high_sum >= ADLER_MOD) begin
            high_sum = high_sum - ADLER_MOD;
        end
        return {high_sum[15:0], low_sum[15:0]};
    endfunction

endpackage

@@ rtl/rfd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_core
// Input register, configuration registers and the per-byte framing logic.
// ----------------------------------------------------------------------------
module rfd_core import rfd_pkg::*; #(
    parameter int TAG_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_hold,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam logic [30:0] MIN_FRAME = 31'(TAG_BYTES + CHECK_BYTES);
    localparam logic [30:0] TAG_LEN   = 31'(TAG_BYTES);

    typedef enum logic [2:0] {
        ST_HEADER = 3'b001,
        ST_BODY   = 3'b010,
        ST_STUCK  = 3'b100
    } t_state;

    logic [30:0] r_min_length;
    logic [30:0] r_max_length;
    logic [31:0] r_tag_word;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_state      r_state,   n_state;
    logic [30:0] r_count,   n_count;
    logic [31:0] r_len,     n_len;
    logic [30:0] r_pay_end, n_pay_end;
    logic [30:0] r_last,    n_last;
    logic [15:0] r_low,     n_low;
    logic [15:0] r_high,    n_high;
    logic        r_tag_ok,  n_tag_ok;
    logic [31:0] r_rc,      n_rc;

    logic        process_en;
    logic [31:0] adler_next;
    logic [3:0]  tag_idx;
    logic [7:0]  tag_want;
    logic        len_bad;

    assign o_stall    = i_hold;
    assign process_en = r_in_valid && !i_hold;
    assign adler_next = adler_step(r_low, r_high, r_in_byte);
    assign tag_idx    = 4'(TAG_BYTES - 1) - {1'b0, r_count[2:0]};
    assign tag_want   = (tag_idx[3:2] == 2'b00) ?
                        r_tag_word[{tag_idx[1:0], 3'b000} +: 8] : 8'h00;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_pay_end   = r_pay_end;
        n_last      = r_last;
        n_low       = r_low;
        n_high      = r_high;
        n_tag_ok    = r_tag_ok;
        n_rc        = r_rc;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_PAYLOAD, payload_byte: 8'h00, verdict: VERDICT_OK};
        len_bad     = 1'b0;
        if (process_en) begin
            unique case (r_state)
                ST_HEADER: begin
                    n_len = {r_len[23:0], r_in_byte};
                    if (r_count[1:0] == 2'(HEADER_BYTES - 1)) begin
                        len_bad = n_len[31] || (n_len[30:0] < r_min_length) ||
                                  (n_len[30:0] > r_max_length) ||
                                  (n_len[30:0] < MIN_FRAME);
                        if (len_bad) begin
                            n_state     = ST_STUCK;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_VERDICT;
                            o_res.verdict = VERDICT_LENGTH;
                        end else begin
                            n_state   = ST_BODY;
                            n_count   = '0;
                            n_pay_end = n_len[30:0] - 31'(CHECK_BYTES);
                            n_last    = n_len[30:0] - 31'd1;
                        end
                    end else begin
                        n_count = r_count + 31'd1;
                    end
                end
                ST_BODY: begin
                    if (r_count < TAG_LEN || r_count < r_pay_end) begin
                        n_low   = adler_next[15:0];
                        n_high  = adler_next[31:16];
                        n_count = r_count + 31'd1;
                        if (r_count < TAG_LEN) begin
                            if (tag_want != r_in_byte) begin
                                n_tag_ok = 1'b0;
                            end
                        end else begin
                            o_res_valid        = 1'b1;
                            o_res.payload_byte = r_in_byte;
                        end
                    end else begin
                        n_rc = {r_rc[23:0], r_in_byte};
                        if (r_count == r_last) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_VERDICT;
                            // checksum mismatch outranks a tag mismatch
                            if ({r_high, r_low} != n_rc) begin
                                o_res.verdict = VERDICT_CHECKSUM;
                            end else if (!r_tag_ok) begin
                                o_res.verdict = VERDICT_TAG;
                            end
                            if (o_res.verdict != VERDICT_OK) begin
                                n_state = ST_STUCK;
                            end else begin
                                n_state  = ST_HEADER;
                                n_count  = '0;
                                n_len    = '0;
                                n_low    = 16'd1;
                                n_high   = 16'd0;
                                n_tag_ok = 1'b1;
                                n_rc     = '0;
                            end
                        end else begin
                            n_count = r_count + 31'd1;
                        end
                    end
                end
                ST_STUCK: begin
                    // drop every byte until reset
                end
                default: begin
                    n_state = ST_STUCK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RST;
            r_max_length <= MAX_LENGTH_RST;
            r_tag_word   <= TAG_WORD_RST;
            r_in_valid   <= 1'b0;
            r_state      <= ST_HEADER;
            r_count      <= '0;
            r_len        <= '0;
            r_pay_end    <= '0;
            r_last       <= '0;
            r_low        <= 16'd1;
            r_high       <= 16'd0;
            r_tag_ok     <= 1'b1;
            r_rc         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MIN_LENGTH: r_min_length <= i_cfg_data[30:0];
                    CFG_MAX_LENGTH: r_max_length <= i_cfg_data[30:0];
                    CFG_TAG_WORD:   r_tag_word   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (!i_hold) begin
                r_in_valid <= i_valid;
            end
            r_state   <= n_state;
            r_count   <= n_count;
            r_len     <= n_len;
            r_pay_end <= n_pay_end;
            r_last    <= n_last;
            r_low     <= n_low;
            r_high    <= n_high;
            r_tag_ok  <= n_tag_ok;
            r_rc      <= n_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_hold) begin
            r_in_byte <= i_in_byte;
        end
    end

    a_stuck_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STUCK |=> r_state == ST_STUCK)
        else $error("deframer left the error state before reset");

    a_stuck_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STUCK |-> !o_res_valid)
        else $error("result produced after a sticky error");

    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_VERDICT && o_res.verdict != VERDICT_OK)
        |=> r_state == ST_STUCK)
        else $error("error verdict did not lock the deframer");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_PAYLOAD) |-> o_res.verdict == VERDICT_OK)
        else $error("payload result carries a verdict");

endmodule

@@ rtl/rfd_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_out_buf
// Result register with one skid entry so a stalled result does not block input.
// ----------------------------------------------------------------------------
module rfd_out_buf import rfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_hold,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_hold   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with an empty result register");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_res_valid)
        else $error("result written while the skid entry is full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && r_out == $past(r_skid)))
        else $error("skid entry not moved to the result register");

endmodule

@@ rtl/rpc_frame_deframer_top.sv @@
`timescale 1ns / 1ps
// Each byte passes the core input register, then its result enters the output register.
// Throughput: one byte per cycle unless stalled; framing and Adler-32 are combinational.
// A result waiting under stall is held in a skid entry, so input stalls only when both fill.
// Reset: synchronous, active low; clears framing state, sticky error and sets the
// registers to min_length 8, max_length 67108864, tag_word 0. No clearing pass.
// ----------------------------------------------------------------------------
// rpc_frame_deframer_top
// Deframes length-prefixed frames, checks type tag and Adler-32, and passes
// payload bytes on with a verdict at the end of each frame.
// ----------------------------------------------------------------------------
module rpc_frame_deframer_top import rfd_pkg::*; #(
    parameter int TAG_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_verdict,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic    hold;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // Framing logic: input register, length/tag/checksum tracking, sticky error.
    rfd_core #(
        .TAG_BYTES (TAG_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hold      (hold),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register plus skid entry; hold back the core while the skid is full.
    rfd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_hold      (hold),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (out_res)
    );

    // Unpack the result transfer onto the field ports.
    assign o_result_kind  = out_res.kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_verdict      = out_res.verdict;

endmodule
